[rtl/lfe_pkg.sv]
package lfe_pkg;

  // Item codes carried on in_mode
  localparam logic [1:0] MODE_TOGGLE = 2'd0;
  localparam logic [1:0] MODE_STEP   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // B3/S23 neighbor counts
  localparam logic [3:0] LIFE_SURVIVE_LOW = 4'd2;
  localparam logic [3:0] LIFE_BIRTH       = 4'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DONE,
    ST_STEP
  } lfe_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;    // capture mode, col, row
    logic rd_cell;     // read the addressed row
    logic rd_step;     // read the sweep row picked by the count
    logic save_row0;   // keep the original row 0 for the last row
    logic shift_mem;   // shift the row window with memory data
    logic shift_row0;  // shift the row window with the saved row 0
    logic wr_gen;      // write a computed generation row
    logic wr_clear;    // write an all-dead row
    logic wr_cell;     // write back a toggled row
    logic resp_cell;   // emit the addressed cell
    logic resp_zero;   // emit a zero result
  } lfe_cmd_t;

endpackage

[rtl/lfe_ctrl.sv]
module lfe_ctrl #(
  parameter int GRID_ROWS = 64,
  parameter int CW        = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_mode,
  output logic              busy,
  output lfe_pkg::lfe_cmd_t cmd,
  output logic [CW-1:0]     cnt
);

  lfe_pkg::lfe_state_t state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfe_pkg::ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      lfe_pkg::ST_CLEAR: begin
        cmd.wr_clear = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(GRID_ROWS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = lfe_pkg::ST_IDLE;
        end
      end
      lfe_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch_in = 1'b1;
          cnt_nxt      = '0;
          if (in_mode == lfe_pkg::MODE_STEP) begin
            state_nxt = lfe_pkg::ST_STEP;
          end else begin
            state_nxt = lfe_pkg::ST_CELL_RD;
          end
        end
      end
      lfe_pkg::ST_CELL_RD: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = lfe_pkg::ST_CELL_DONE;
      end
      lfe_pkg::ST_CELL_DONE: begin
        cmd.wr_cell   = 1'b1;
        cmd.resp_cell = 1'b1;
        state_nxt     = lfe_pkg::ST_IDLE;
      end
      lfe_pkg::ST_STEP: begin
        // reads lead, the window shifts on the registered read data, writes trail
        cmd.rd_step    = (cnt_r <= CW'(GRID_ROWS));
        cmd.save_row0  = (cnt_r == CW'(2));
        cmd.shift_mem  = (cnt_r >= CW'(1)) && (cnt_r <= CW'(GRID_ROWS + 1));
        cmd.shift_row0 = (cnt_r == CW'(GRID_ROWS + 2));
        cmd.wr_gen     = (cnt_r >= CW'(4));
        cnt_nxt        = cnt_r + CW'(1);
        if (cnt_r == CW'(GRID_ROWS + 3)) begin
          cmd.resp_zero = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = lfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign cnt = cnt_r;

endmodule

[rtl/lfe_datapath.sv]
module lfe_datapath #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64,
  parameter int CW        = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfe_pkg::lfe_cmd_t cmd,
  input  logic [CW-1:0]     cnt,
  input  logic [1:0]        in_mode,
  input  logic [5:0]        in_col,
  input  logic [5:0]        in_row,
  output logic              out_valid,
  output logic              out_cell_alive
);

  localparam int AW  = $clog2(GRID_ROWS);
  localparam int CLW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data_r;
  logic [GRID_COLS-1:0] up_r, cur_r, dn_r, row0_r;
  logic [GRID_COLS-1:0] gen_row, flip_row, wr_data, shift_in;
  logic [1:0]           mode_r;
  logic [5:0]           col_r, row_r;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [CLW-1:0]       col_idx;
  logic                 in_grid, is_toggle, is_read, wr_en;
  logic                 out_valid_r, out_cell_alive_r;
  logic                 out_valid_nxt, out_cell_alive_nxt;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r <= in_mode;
      col_r  <= in_col;
      row_r  <= in_row;
    end
  end

  assign in_grid   = (7'(col_r) < 7'(GRID_COLS)) && (11'(row_r) < 11'(GRID_ROWS));
  assign is_toggle = (mode_r == lfe_pkg::MODE_TOGGLE);
  assign is_read   = (mode_r == lfe_pkg::MODE_READ);
  assign col_idx   = col_r[CLW-1:0];

  always_comb begin
    if (cmd.rd_cell) begin
      rd_addr = AW'(row_r);
    end else if (cnt == '0) begin
      rd_addr = AW'(GRID_ROWS - 1);
    end else begin
      rd_addr = AW'(cnt - CW'(1));
    end
  end

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_cell || cmd.rd_step) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Three-row window over the old grid
  assign shift_in = cmd.shift_row0 ? row0_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.shift_mem || cmd.shift_row0) begin
      up_r  <= cur_r;
      cur_r <= dn_r;
      dn_r  <= shift_in;
    end
    if (cmd.save_row0) begin
      row0_r <= rd_data_r;
    end
  end

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
    localparam int LF = (c + GRID_COLS - 1) % GRID_COLS;
    localparam int RT = (c + 1) % GRID_COLS;
    logic [3:0] n;
    assign n = 4'(up_r[LF]) + 4'(up_r[c]) + 4'(up_r[RT])
             + 4'(cur_r[LF]) + 4'(cur_r[RT])
             + 4'(dn_r[LF]) + 4'(dn_r[c]) + 4'(dn_r[RT]);
    assign gen_row[c] = (n == lfe_pkg::LIFE_BIRTH)
                      || (cur_r[c] && (n == lfe_pkg::LIFE_SURVIVE_LOW));
  end

  assign flip_row = rd_data_r ^ (GRID_COLS'(1) << col_idx);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(cnt);
    wr_data = '0;
    priority if (cmd.wr_clear) begin
      wr_en = 1'b1;
    end else if (cmd.wr_gen) begin
      wr_en   = 1'b1;
      wr_addr = AW'(cnt - CW'(4));
      wr_data = gen_row;
    end else if (cmd.wr_cell) begin
      wr_en   = is_toggle && in_grid;
      wr_addr = AW'(row_r);
      wr_data = flip_row;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt      = cmd.resp_cell || cmd.resp_zero;
    out_cell_alive_nxt = 1'b0;
    if (cmd.resp_cell && in_grid && (is_toggle || is_read)) begin
      out_cell_alive_nxt = is_toggle ? flip_row[col_idx] : rd_data_r[col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_cell_alive_r <= out_cell_alive_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_alive_r;

endmodule

[rtl/life_grid_generation_engine.sv]
// Conway B3/S23 engine on a toroidal GRID_COLS x GRID_ROWS grid. Raise start
// with in_mode/in_col/in_row while busy is low to hand over one item: toggle
// (flip a cell), step (advance one generation) or read. Every item yields one
// result beat: out_valid is high for exactly one cycle with out_cell_alive,
// the addressed cell after the operation (0 for a step, for an unused mode,
// or for an address outside the grid). There is no back-pressure on the
// result side; capture the beat when it appears. After reset the grid memory
// is cleared one row per cycle with busy high. A toggle or read goes from
// accept through a row read to the write-back and the result register. A
// step sweeps the grid memory once, a row per cycle, through a three-row
// window, with the computed rows written back behind the reads. A new item
// may be accepted in the cycle the result beat is shown.
module life_grid_generation_engine #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_col,
  input  logic [5:0] in_row,
  output logic       out_valid,
  output logic       out_cell_alive
);

  // Sweep counter must reach GRID_ROWS + 3
  localparam int CW = $clog2(GRID_ROWS + 4);

  lfe_pkg::lfe_cmd_t cmd;
  logic [CW-1:0]     cnt;

  // Sequence clearing, cell access and the generation sweep
  lfe_ctrl #(
    .GRID_ROWS (GRID_ROWS),
    .CW        (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .cmd     (cmd),
    .cnt     (cnt)
  );

  // Hold the grid memory, the row window and the result register
  lfe_datapath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .CW        (CW)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cnt            (cnt),
    .in_mode        (in_mode),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_cell_alive (out_cell_alive)
  );

endmodule

[bench/life_cell_checker.sv]
module life_cell_checker
  import lfe_pkg::*;
#(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_col,
  input  logic [5:0] in_row,
  input  logic       out_valid,
  input  logic       out_cell_alive,
  output int         fails,
  output int         pending
);

  // Shadow copy of the grid: bit c of word r is the cell at column c, row r
  logic [63:0] life_grid [GRID_ROWS];
  logic        cell_due [$];
  logic        due_alive;
  int          fail_tally;

  // Advance the shadow grid by one B3/S23 generation, all cells from the old grid
  task automatic advance_shadow_grid();
    logic [63:0] fresh [GRID_ROWS];
    int up, dn, lf, rt, n;
    for (int r = 0; r < GRID_ROWS; r++) begin
      up = (r + GRID_ROWS - 1) % GRID_ROWS;
      dn = (r + 1) % GRID_ROWS;
      fresh[r] = '0;
      for (int c = 0; c < GRID_COLS; c++) begin
        lf = (c + GRID_COLS - 1) % GRID_COLS;
        rt = (c + 1) % GRID_COLS;
        n = 0;
        n += life_grid[up][lf];
        n += life_grid[up][c];
        n += life_grid[up][rt];
        n += life_grid[r][lf];
        n += life_grid[r][rt];
        n += life_grid[dn][lf];
        n += life_grid[dn][c];
        n += life_grid[dn][rt];
        if (life_grid[r][c])
          fresh[r][c] = (n == int'(LIFE_SURVIVE_LOW)) || (n == int'(LIFE_BIRTH));
        else
          fresh[r][c] = (n == int'(LIFE_BIRTH));
      end
    end
    for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = fresh[r];
  endtask

  // Apply one accepted beat to the shadow grid and return the cell it reports
  task automatic apply_life_item(input logic [1:0] mode, input logic [5:0] col,
                                 input logic [5:0] row, output logic alive);
    logic in_grid;
    in_grid = (int'(col) < GRID_COLS) && (int'(row) < GRID_ROWS);
    alive = 1'b0;
    case (mode)
      MODE_TOGGLE: begin
        if (in_grid) begin
          life_grid[row][col] = ~life_grid[row][col];
          alive = life_grid[row][col];
        end
      end
      MODE_STEP: begin
        advance_shadow_grid();
      end
      MODE_READ: begin
        if (in_grid) alive = life_grid[row][col];
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    fail_tally = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < GRID_ROWS; r++) life_grid[r] = '0;
      cell_due.delete();
    end else begin
      // retire the result beat first: it belongs to an earlier item
      if (out_valid === 1'b1) begin
        if (cell_due.size() == 0) begin
          $error("result beat with no item outstanding (cell_alive %0b)", out_cell_alive);
          fail_tally++;
        end else begin
          due_alive = cell_due.pop_front();
          if (out_cell_alive !== due_alive) begin
            $error("cell_alive mismatch: expected %0b, actual %0b", due_alive,
                   out_cell_alive);
            fail_tally++;
          end
        end
      end
      if (start && (busy === 1'b0)) begin
        apply_life_item(in_mode, in_col, in_row, due_alive);
        cell_due.push_back(due_alive);
      end
    end
    fails   <= fail_tally;
    pending <= cell_due.size();
  end

endmodule

[bench/tb.sv]
module tb;
  import lfe_pkg::*;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  // mode value the block ignores: no grid change, cell_alive 0
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // quiet cycles allowed before the run is declared hung; it must outlast a
  // whole step and the post-reset clear pass
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1030;
  localparam int MAX_GAP = 16;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_mode;
  logic [5:0] in_col;
  logic [5:0] in_row;
  logic       out_valid;
  logic       out_cell_alive;
  int         fails;
  int         pending;

  // percent chance of holding start low before each beat
  int         idle_pct;
  // corner of the 8x8 window where most random traffic lands
  logic [5:0] win_col;
  logic [5:0] win_row;

  life_grid_generation_engine #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_cell_alive(out_cell_alive)
  );

  life_cell_checker #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_cell_alive(out_cell_alive),
    .fails         (fails),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hand one beat to the block. Entered and left at a falling edge; the
  // optional idle gap scribbles junk on the payload while start is low.
  task automatic send_item(input logic [1:0] mode, input logic [5:0] col,
                           input logic [5:0] row);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_mode <= 2'($urandom);
      in_col  <= 6'($urandom);
      in_row  <= 6'($urandom);
      @(negedge clk);
      gap++;
    end
    start   <= 1'b1;
    in_mode <= mode;
    in_col  <= col;
    in_row  <= row;
    // hold the beat until the block takes it at a rising edge with busy low
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // Mostly toggles and reads packed into a small window, so that patterns
  // form, collide and wrap across the edges when steps come through.
  task automatic send_random_item();
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      mode = MODE_TOGGLE;
    else if (pick < 75) mode = MODE_READ;
    else if (pick < 90) mode = MODE_STEP;
    else if (pick < 95) mode = MODE_UNUSED;
    else                mode = 2'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      col = 6'($urandom);
      row = 6'($urandom);
    end else begin
      // window offsets wrap modulo 64 through the 6-bit add
      col = win_col + 6'($urandom_range(0, 7));
      row = win_row + 6'($urandom_range(0, 7));
    end
    send_item(mode, col, row);
  endtask

  // Stimulus: directed corner cases first, then random phases.
  initial begin
    int idle_plan [4];
    idle_plan = '{0, 52, 0, 11};
    rst_n    = 1'b0;
    start    = 1'b0;
    in_mode  = MODE_TOGGLE;
    in_col   = '0;
    in_row   = '0;
    idle_pct = 0;
    win_col  = '0;
    win_row  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // the four corners are mutual neighbors on the torus: each sees three
    send_item(MODE_TOGGLE, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd0);
    send_item(MODE_TOGGLE, 6'd63, 6'd63);
    send_item(MODE_TOGGLE, 6'd63, 6'd0);
    send_item(MODE_TOGGLE, 6'd0, 6'd63);
    send_item(MODE_STEP, 6'd63, 6'd63);
    send_item(MODE_READ, 6'd63, 6'd63);
    send_item(MODE_READ, 6'd1, 6'd1);
    // blinker straddling the column wrap on row 10
    send_item(MODE_TOGGLE, 6'd63, 6'd10);
    send_item(MODE_TOGGLE, 6'd0, 6'd10);
    send_item(MODE_TOGGLE, 6'd1, 6'd10);
    send_item(MODE_STEP, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd9);
    send_item(MODE_READ, 6'd0, 6'd11);
    send_item(MODE_READ, 6'd63, 6'd10);
    // unused mode must leave the grid alone and report dead
    send_item(MODE_UNUSED, 6'd63, 6'd63);
    send_item(MODE_UNUSED, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd63, 6'd63);
    // kill one corner, step again, toggle a cell back off
    send_item(MODE_TOGGLE, 6'd0, 6'd0);
    send_item(MODE_STEP, 6'd0, 6'd0);
    send_item(MODE_READ, 6'd0, 6'd10);
    send_item(MODE_TOGGLE, 6'd5, 6'd40);
    send_item(MODE_TOGGLE, 6'd5, 6'd40);

    // random phases: no idling, sender idle about half the time, and light idling
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 128 == 0) idle_pct = idle_plan[(i / 128) % 4];
      if (i % 96 == 0) begin
        win_col = 6'($urandom);
        win_row = 6'($urandom);
      end
      send_random_item();
    end
    start <= 1'b0;

    // drain: wait for every outstanding beat, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (GRID_ROWS + 8) @(posedge clk);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || out_valid === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/lfe_pkg.sv
rtl/lfe_ctrl.sv
rtl/lfe_datapath.sv
rtl/life_grid_generation_engine.sv
bench/life_cell_checker.sv
bench/tb.sv
